@@ design/frwf_pkg.sv @@
// Package for the first repeated word finder.
// Holds the control state type and the control bundle broadcast to the word cells.
// No dependencies.
package frwf_pkg;

	// Fixed widths that cover the whole legal parameter range
	localparam int LEN_W = 6;   // word length, up to 63 kept characters
	localparam int CNT_W = 11;  // stored word count, up to 1024 slots

	typedef enum logic {
		ST_ACCEPT,
		ST_EMIT
	} state_t;

	// Broadcast from the control logic to every cell in the row
	typedef struct packed {
		logic [7:0]       ch;        // lowercased character
		logic [LEN_W-1:0] pos;       // character position in the current word
		logic             store_en;  // a kept character arrives
		logic             first;     // first character of a word
		logic             close_en;  // word stored into the slot at count
		logic [LEN_W-1:0] cur_len;   // length of the word being closed
		logic [CNT_W-1:0] count;     // number of stored words
	} cell_ctl_t;

endpackage

@@ design/first_repeated_word_finder.sv @@
// Top level of the first repeated word finder.
// Depends on frwf_pkg and frwf_cell.
//
// Takes one text byte per cycle while in_stall is low; a zero byte ends the
// text. Each stored word sits in its own cell, and every cell compares the
// broadcast character with its own word in the same cycle. A repeated word of
// length L is sent as L transfers, one per cycle while out_stall is low, from
// the current word buffer; input is stalled until its last transfer is taken.
// A not-found result is a single transfer. Stored words need no clearing after
// reset: only slots below the word count are ever compared.
module first_repeated_word_finder #(
	parameter int WORD_SLOTS = 64,
	parameter int KEPT_CHARS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic [7:0] word_char,
	output logic       last
);
	import frwf_pkg::*;

	localparam int PW = (KEPT_CHARS > 1) ? $clog2(KEPT_CHARS) : 1;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(WORD_SLOTS);
	localparam logic [LEN_W-1:0] KEPT_C  = LEN_W'(KEPT_CHARS);

	state_t           state_q, state_d;
	logic [6:0]       cap_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] len_q;
	logic             inside_q;
	logic             answer_q;
	logic [7:0]       word_q [KEPT_CHARS];
	logic [LEN_W-1:0] emit_len_q;
	logic [LEN_W-1:0] emit_idx_q;
	logic             out_valid_q, found_q, last_q;
	logic [7:0]       char_q;

	logic             acc, take, is_end, is_word, is_upper, slots_free;
	logic [7:0]       lc;
	logic             any_hit, do_finish, store_en, close_en, new_answer;
	logic             too_long, emit_nf, emit_word;
	logic [WORD_SLOTS-1:0] hit_vec;
	cell_ctl_t        ctl;

	// Byte classification
	always_comb begin
		is_end   = (text_byte == 8'd0);
		is_upper = text_byte inside {[8'h41:8'h5A]};
		is_word  = text_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
		lc       = is_upper ? (text_byte + 8'h20) : text_byte;
	end

	assign in_stall = (state_q == ST_EMIT) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;

	// Word handling decisions
	always_comb begin
		slots_free = (count_q < SLOTS_C);
		any_hit    = |hit_vec;
		do_finish  = acc && !answer_q && inside_q && (is_end || !is_word);
		store_en   = acc && !is_end && !answer_q && is_word && slots_free && (len_q < KEPT_C);
		close_en   = do_finish && slots_free && !any_hit;
		new_answer = do_finish && slots_free && any_hit;
		too_long   = ({1'b0, len_q} >= cap_q);
		emit_word  = new_answer && !too_long;
		emit_nf    = (new_answer && too_long) ||
		             (acc && is_end && !answer_q && !new_answer);
	end

	always_comb begin
		ctl.ch       = lc;
		ctl.pos      = len_q;
		ctl.store_en = store_en;
		ctl.first    = (len_q == '0);
		ctl.close_en = close_en;
		ctl.cur_len  = len_q;
		ctl.count    = count_q;
	end

	// Row of word cells
	for (genvar i = 0; i < WORD_SLOTS; i++) begin : g_cell
		frwf_cell #(
			.KEPT_CHARS(KEPT_CHARS),
			.IDX       (i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.hit(hit_vec[i])
		);
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'd64;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			len_q    <= '0;
			inside_q <= 1'b0;
			answer_q <= 1'b0;
		end else if (acc) begin
			if (is_end) begin
				count_q  <= '0;
				len_q    <= '0;
				inside_q <= 1'b0;
				answer_q <= 1'b0;
			end else if (!answer_q) begin
				if (is_word) begin
					inside_q <= 1'b1;
					if (store_en) begin
						len_q <= len_q + 1'b1;
					end
				end else if (inside_q) begin
					len_q    <= '0;
					inside_q <= 1'b0;
					if (close_en) begin
						count_q <= count_q + 1'b1;
					end
					if (new_answer) begin
						answer_q <= 1'b1;
					end
				end
			end
		end
	end

	// Current word buffer
	always_ff @(posedge clk) begin
		if (store_en) begin
			word_q[len_q[PW-1:0]] <= lc;
		end
	end

	// Emit state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCEPT: begin
				if (emit_word && (len_q != LEN_W'(1))) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (take && last_q) begin
					state_d = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_nf || emit_word) begin
			out_valid_q <= 1'b1;
		end else if (take && (state_q == ST_ACCEPT || last_q)) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_nf) begin
			found_q <= 1'b0;
			char_q  <= 8'd0;
			last_q  <= 1'b1;
		end else if (emit_word) begin
			found_q    <= 1'b1;
			char_q     <= word_q[0];
			last_q     <= (len_q == LEN_W'(1));
			emit_len_q <= len_q;
			emit_idx_q <= LEN_W'(1);
		end else if (state_q == ST_EMIT && take && !last_q) begin
			char_q     <= word_q[emit_idx_q[PW-1:0]];
			last_q     <= ((emit_idx_q + 1'b1) == emit_len_q);
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign word_char = char_q;
	assign last      = last_q;

endmodule

@@ design/frwf_cell.sv @@
// One word slot of the finder row: stores a word and tracks whether the word
// being collected still equals it. Depends on frwf_pkg.
module frwf_cell #(
	parameter int KEPT_CHARS = 32,
	parameter int IDX        = 0
) (
	input  logic               clk,
	input  frwf_pkg::cell_ctl_t ctl,
	output logic               hit
);
	import frwf_pkg::*;

	localparam int PW = (KEPT_CHARS > 1) ? $clog2(KEPT_CHARS) : 1;
	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [7:0]       chars_q [KEPT_CHARS];
	logic [LEN_W-1:0] len_q;
	logic             match_q;
	logic             mine;
	logic             eq;

	assign mine = (ctl.count == MY_IDX);
	assign eq   = (chars_q[ctl.pos[PW-1:0]] == ctl.ch);

	// Character store, length store and running compare
	always_ff @(posedge clk) begin
		if (ctl.store_en) begin
			if (mine) begin
				chars_q[ctl.pos[PW-1:0]] <= ctl.ch;
			end
			match_q <= (ctl.first | match_q) & eq;
		end
		if (ctl.close_en && mine) begin
			len_q <= ctl.cur_len;
		end
	end

	// Only slots below the count hold a word
	assign hit = (MY_IDX < ctl.count) && match_q && (len_q == ctl.cur_len);

endmodule

@@ dv/tb_first_repeated_word_finder.sv @@
// Testbench for first_repeated_word_finder: drives texts byte by byte, predicts
// the repeated-word runs in a behavioral model and compares every transfer.
// Depends on frwf_pkg and first_repeated_word_finder.
`timescale 1ns / 100ps

module tb_first_repeated_word_finder;
	import frwf_pkg::*;

	localparam int SLOTS = 64;
	localparam int KEEP = 32;
	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 40;
	localparam int RAND_ITEMS = 15;  // random bytes per idling phase

	typedef struct packed {
		logic       found;
		logic [7:0] ch;
		logic       last;
	} word_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       found;
	logic [7:0] word_char;
	logic       last;

	first_repeated_word_finder u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .word_char(word_char), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic [7:0] word_store [SLOTS][KEEP];
	logic [5:0] stored_len [SLOTS];
	int         word_cnt;
	int         cur_len;
	bit         in_word;
	bit         answered;
	int         capacity;

	word_result_t expected_q[$];
	word_result_t pred_log[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_sent = 0;

	function automatic bit is_word_char(logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic void clear_text();
		word_cnt = 0;
		cur_len = 0;
		in_word = 0;
		answered = 0;
	endfunction

	function automatic void push_expected(word_result_t r);
		expected_q.push_back(r);
		pred_log.push_back(r);
	endfunction

	// Close the current word: when a slot is free, report it if repeated, else store it
	function automatic void close_word();
		int len;
		bool_match: begin
		end
		len = cur_len;
		cur_len = 0;
		in_word = 0;
		if (word_cnt >= SLOTS)
			return;
		for (int j = 0; j < word_cnt; j++) begin
			bit same;
			same = (stored_len[j] == len);
			for (int p = 0; p < len && same; p++)
				if (word_store[j][p] != word_store[word_cnt][p])
					same = 0;
			if (same) begin
				answered = 1;
				if (len >= capacity)
					push_expected('{1'b0, 8'h00, 1'b1});
				else
					for (int p = 0; p < len; p++)
						push_expected('{1'b1, word_store[word_cnt][p], p == len - 1});
				return;
			end
		end
		stored_len[word_cnt] = len[5:0];
		word_cnt++;
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		if (b == 8'h00) begin
			if (!answered) begin
				if (in_word)
					close_word();
				if (!answered)
					push_expected('{1'b0, 8'h00, 1'b1});
			end
			clear_text();
			return;
		end
		if (answered)
			return;
		if (is_word_char(b)) begin
			in_word = 1;
			if (word_cnt < SLOTS && cur_len < KEEP) begin
				word_store[word_cnt][cur_len] = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
				cur_len++;
			end
		end else if (in_word) begin
			close_word();
		end
	endfunction

	// Send one byte: random gap, then hold until accepted; valid stays high
	// after the transfer so back-to-back bytes need no gap
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_byte(b);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_capacity(int value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[6:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		capacity = value;
	endtask

	// Short distinct word for slot w: one character, then "x" and one character
	function automatic string slot_word(int w);
		string digits;
		digits = "0123456789abcdefghijklmnopqrstuvwxyz";
		if (w < 36)
			return $sformatf("%c", digits[w]);
		return $sformatf("x%c", digits[w - 36]);
	endfunction

	// Short random word of letters and digits, biased toward a, b and c so repeats are common
	function automatic string rand_word(int maxlen);
		string w;
		int n;
		w = "";
		n = $urandom_range(maxlen, 1);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: w = {w, string'(byte'("a" + $urandom_range(2)))};
				1: w = {w, string'(byte'("A" + $urandom_range(25)))};
				2: w = {w, string'(byte'("0" + $urandom_range(9)))};
				default: w = {w, string'(byte'("a" + $urandom_range(25)))};
			endcase
		end
		return w;
	endfunction

	function automatic logic [7:0] rand_separator();
		logic [7:0] b;
		do b = 8'($urandom_range(255, 1)); while (is_word_char(b));
		return b;
	endfunction

	// Receiver stall and output check
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transfer found=%0d word_char=%0h last=%0d",
					found, word_char, last);
				errors++;
			end else begin
				word_result_t e;
				e = expected_q.pop_front();
				if (found !== e.found) begin
					$error("found: expected %0d actual %0d", e.found, found);
					errors++;
				end
				if (word_char !== e.ch) begin
					$error("word_char: expected %0h actual %0h", e.ch, word_char);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d actual %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_first_repeated_word_finder failed");
			$finish;
		end
	end

	// Directed texts: expected results for the simple rows are typed in
	typedef struct {
		string        text;
		int           cap;
		bit           typed;
		word_result_t exp;
	} text_row_t;

	text_row_t directed[] = '{
		'{"",                       64, 1, '{1'b0, 8'h00, 1'b1}},
		'{"one two three",          64, 1, '{1'b0, 8'h00, 1'b1}},
		'{"Ab ab",                  64, 0, '0},
		'{"x\xff\x80x",             64, 0, '0},
		'{"09 zZ 09",               64, 0, '0},
		'{"cat dog cat dog",        3,  1, '{1'b0, 8'h00, 1'b1}},
		'{"aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaXYZ",
		                            64, 0, '0},
		'{"q q",                    1,  1, '{1'b0, 8'h00, 1'b1}},
		'{"q q",                    0,  1, '{1'b0, 8'h00, 1'b1}},
		'{"end at word word",       64, 0, '0},
		'{"hi hi hi ignored",       127, 0, '0}
	};

	initial begin
		int rand_base;
		ref_init: begin
			capacity = 64;
			clear_text();
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].cap != capacity)
				write_capacity(directed[i].cap);
			pred_log.delete();
			send_string(directed[i].text);
			send_byte(8'h00);
			if (directed[i].typed && (pred_log.size() != 1
					|| pred_log[0] != directed[i].exp)) begin
				$error("directed row %0d: table and predictor disagree", i);
				errors++;
			end
		end

		// Slots full: 64 distinct words, then a repeat that is ignored
		write_capacity(64);
		for (int w = 0; w < SLOTS; w++)
			send_string({slot_word(w), " "});
		send_string("0 1");
		send_byte(8'h00);

		// Random texts in three idling phases
		rand_base = n_sent;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 57 : 0;
			recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 34 : 0;
			write_capacity(phase == 0 ? $urandom_range(127) : phase == 1 ? 127 : 64);
			while (n_sent < rand_base + RAND_ITEMS * (phase + 1)) begin
				int nw;
				nw = $urandom_range(6, 1);
				for (int w = 0; w < nw && n_sent < rand_base + RAND_ITEMS * (phase + 1);
						w++) begin
					string s;
					s = rand_word($urandom_range(9) == 0 ? 36 : 5);
					send_string(s);
					if ($urandom_range(9) == 0) begin
						send_byte(8'($urandom_range(255, 1)));
					end else begin
						send_byte(rand_separator());
					end
				end
				send_byte(8'h00);
			end
		end

		wait_idle();
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_first_repeated_word_finder passed");
		else
			$display("tb_first_repeated_word_finder failed");
		$finish;
	end

endmodule

@@ first_repeated_word_finder.f @@
design/frwf_pkg.sv
design/frwf_cell.sv
design/first_repeated_word_finder.sv
dv/tb_first_repeated_word_finder.sv
